/* rtl/pcpa_pkg.sv */
// Package for the per-CPU page allocator: widths, status codes, state type
// and the shared address check struct. Depends on nothing.
`timescale 1ns / 1ps
package pcpa_pkg;
   localparam int ADDR_W = 40;
   localparam int PAGE_SHIFT = 12;
   localparam int CPU_ID_W = 3;
   localparam int PAGE_NUM_W = ADDR_W - PAGE_SHIFT + 1;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;

   localparam int CPU_COUNT_DEF = 8;
   localparam int STEAL_MAX_DEF = 8;
   localparam int PAGE_COUNT_DEF = 32768;

   localparam logic [ADDR_W-1:0] LOW_ADDR_RST = 40'h0080000000;
   localparam logic [ADDR_W-1:0] TOP_ADDR_RST = 40'h0088000000;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_OOM = 2'd1;
   localparam logic [1:0] ST_BADADDR = 2'd2;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_POP_WAIT,
      S_SCAN,
      S_STEAL_WAIT,
      S_PUSH_RD,
      S_PUSH_WR
   } state_type;

   typedef struct packed {
      logic addr_bad;
      logic [PAGE_NUM_W-1:0] free_page;
   } addr_chk_type;
endpackage

/* rtl/pcpa_next_ram.sv */
// Successor table of the free lists: one write port and one registered read port.
// Depends on pcpa_pkg only through the parameters handed down.
`timescale 1ns / 1ps
module pcpa_next_ram #(
   parameter int DEPTH = 32768,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* rtl/pcpa_addr_unit.sv */
// Shared address arithmetic: page base, free address checks and page address rebuild.
// Depends on pcpa_pkg.
`timescale 1ns / 1ps
module pcpa_addr_unit #(
   parameter int PAGE_COUNT = 32768
) (
   input  logic [pcpa_pkg::ADDR_W-1:0]              low_addr,
   input  logic [pcpa_pkg::ADDR_W-1:0]              top_addr,
   input  logic [pcpa_pkg::ADDR_W-1:0]              page_addr,
   input  logic [$clog2(PAGE_COUNT)-1:0]            page_idx,
   output pcpa_pkg::addr_chk_type                   chk,
   output logic [pcpa_pkg::ADDR_W-1:0]              alloc_addr
);
   import pcpa_pkg::*;

   logic [ADDR_W:0] base;
   logic [ADDR_W:0] diff;
   logic [ADDR_W:0] sum;

   always_comb begin
      base = ({1'b0, low_addr} + (ADDR_W+1)'(4095)) & ~(ADDR_W+1)'(4095);
      diff = {1'b0, page_addr} - base;
      sum = base + ((ADDR_W+1)'(page_idx) << PAGE_SHIFT);
      chk.free_page = diff[ADDR_W:PAGE_SHIFT];
      chk.addr_bad = (page_addr[PAGE_SHIFT-1:0] != '0) || (page_addr < low_addr) ||
                     (page_addr >= top_addr) || ({1'b0, page_addr} < base) ||
                     (diff[ADDR_W:PAGE_SHIFT] >= PAGE_NUM_W'(PAGE_COUNT));
      alloc_addr = sum[ADDR_W-1:0];
   end
endmodule

/* rtl/per_cpu_page_allocator_with_steal.sv */
// Top level of the per-CPU page allocator with stealing: sequencer, list heads,
// steal buffer and configuration port. Depends on pcpa_pkg, pcpa_next_ram, pcpa_addr_unit.
`timescale 1ns / 1ps
// A free is done in the decode state, and an allocate that hits its own list waits in the
// pop state for one successor-table read. An allocate from an empty list scans the other
// CPUs in turn, taking one page at a time from each until its list is empty or STEAL_MAX
// pages are taken, waits for the table read of each stolen page, then relinks the stolen
// pages into its own list, reading and then writing the table for each page.
// Each item gives one result, shown for one cycle on rsp_strobe; it cannot be stalled.
module per_cpu_page_allocator_with_steal #(
   parameter int CPU_COUNT = pcpa_pkg::CPU_COUNT_DEF,
   parameter int STEAL_MAX = pcpa_pkg::STEAL_MAX_DEF,
   parameter int PAGE_COUNT = pcpa_pkg::PAGE_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_type,
   input  logic [pcpa_pkg::CPU_ID_W-1:0]     req_cpu_id,
   input  logic [pcpa_pkg::ADDR_W-1:0]       req_page_addr_in,
   output logic                              rsp_strobe,
   output logic [pcpa_pkg::ADDR_W-1:0]       rsp_page_addr_out,
   output logic [1:0]                        rsp_status,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pcpa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pcpa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pcpa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import pcpa_pkg::*;

   localparam int IDX_W = $clog2(PAGE_COUNT);
   localparam int ENT_W = IDX_W + 1;
   localparam int HAW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
   localparam int CW = $clog2(CPU_COUNT + 1);
   localparam int CNT_W = $clog2(STEAL_MAX + 1);
   localparam int BUF_AW = (STEAL_MAX > 1) ? $clog2(STEAL_MAX) : 1;

   state_type state_ff, state_in;
   logic type_ff;
   logic [CPU_ID_W-1:0] cpu_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] low_ff, top_ff;
   logic [ENT_W-1:0] head_ff [CPU_COUNT];
   logic [CW-1:0] c_ff;
   logic [CNT_W-1:0] taken_ff, i_ff;
   logic [IDX_W-1:0] prev_ff, pidx_ff;
   logic [IDX_W-1:0] buf_mem [STEAL_MAX];
   logic [IDX_W-1:0] buf_rd_ff;
   logic rsp_strobe_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic [1:0] rsp_status_ff;

   logic [4:0] cpu5;
   logic cpu_ok;
   logic [HAW-1:0] hsel;
   logic [ENT_W-1:0] head_rd;
   logic scan_done, scan_skip, push_last;
   logic mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [ENT_W-1:0] mem_wdata, mem_rdata;
   logic head_we;
   logic [ENT_W-1:0] head_wdata;
   logic buf_we;
   logic rsp_set;
   logic [1:0] rsp_status_in;
   logic [ADDR_W-1:0] rsp_addr_in;
   logic [IDX_W-1:0] unit_idx;
   addr_chk_type chk;
   logic [ADDR_W-1:0] alloc_addr;
   logic [IDX_W-1:0] free_idx;
   logic csr_wr;

   assign cpu5 = {{(5-CPU_ID_W){1'b0}}, cpu_ff};
   assign cpu_ok = cpu5 < 5'(CPU_COUNT);
   assign hsel = (state_ff == S_SCAN || state_ff == S_STEAL_WAIT) ? c_ff[HAW-1:0]
                                                                  : cpu5[HAW-1:0];
   assign head_rd = head_ff[hsel];
   assign scan_done = (c_ff == CW'(CPU_COUNT)) || (taken_ff == CNT_W'(STEAL_MAX));
   assign scan_skip = (cpu5 == 5'(c_ff)) || !head_rd[IDX_W];
   assign push_last = (i_ff == taken_ff - CNT_W'(1));
   assign free_idx = chk.free_page[IDX_W-1:0];
   assign unit_idx = (state_ff == S_PUSH_WR) ? buf_rd_ff : pidx_ff;

   pcpa_addr_unit #(.PAGE_COUNT(PAGE_COUNT)) u_addr (
      .low_addr(low_ff), .top_addr(top_ff), .page_addr(addr_ff),
      .page_idx(unit_idx), .chk(chk), .alloc_addr(alloc_addr)
   );

   pcpa_next_ram #(.DEPTH(PAGE_COUNT), .WIDTH(ENT_W)) u_next (
      .clock(clock), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
      .raddr(head_rd[IDX_W-1:0]), .rdata(mem_rdata)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (type_ff == REQ_FREE || !cpu_ok) state_in = S_IDLE;
            else if (head_rd[IDX_W]) state_in = S_POP_WAIT;
            else state_in = S_SCAN;
         end
         S_POP_WAIT: state_in = S_IDLE;
         S_SCAN: begin
            if (scan_done) state_in = (taken_ff == '0) ? S_IDLE : S_PUSH_RD;
            else if (!scan_skip) state_in = S_STEAL_WAIT;
         end
         S_STEAL_WAIT: state_in = S_SCAN;
         S_PUSH_RD: state_in = S_PUSH_WR;
         S_PUSH_WR: state_in = push_last ? S_IDLE : S_PUSH_RD;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      mem_we = 1'b0;
      mem_waddr = buf_rd_ff;
      mem_wdata = (i_ff == '0) ? {1'b0, prev_ff} : {1'b1, prev_ff};
      head_we = 1'b0;
      head_wdata = mem_rdata;
      buf_we = 1'b0;
      rsp_set = 1'b0;
      rsp_status_in = ST_OK;
      case (state_ff)
         S_DECODE: begin
            if (type_ff == REQ_FREE) begin
               rsp_set = 1'b1;
               if (!cpu_ok || chk.addr_bad) begin
                  rsp_status_in = ST_BADADDR;
               end else begin
                  mem_we = 1'b1;
                  mem_waddr = free_idx;
                  mem_wdata = head_rd;
                  head_we = 1'b1;
                  head_wdata = {1'b1, free_idx};
               end
            end else if (!cpu_ok) begin
               rsp_set = 1'b1;
               rsp_status_in = ST_OOM;
            end
         end
         S_POP_WAIT: begin
            head_we = 1'b1;
            rsp_set = 1'b1;
         end
         S_SCAN: begin
            if (scan_done) begin
               if (taken_ff == '0) begin
                  rsp_set = 1'b1;
                  rsp_status_in = ST_OOM;
               end
            end else if (!scan_skip) begin
               buf_we = 1'b1;
            end
         end
         S_STEAL_WAIT: head_we = 1'b1;
         S_PUSH_WR: begin
            mem_we = 1'b1;
            if (push_last) begin
               head_we = 1'b1;
               head_wdata = mem_wdata;
               rsp_set = 1'b1;
            end
         end
         default: ;
      endcase
      rsp_addr_in = (rsp_status_in == ST_OK && type_ff == REQ_ALLOC) ? alloc_addr : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         low_ff <= LOW_ADDR_RST;
         top_ff <= TOP_ADDR_RST;
         for (int k = 0; k < CPU_COUNT; k++) head_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         rsp_strobe_ff <= rsp_set;
         if (csr_wr) begin
            if (csr_paddr[3]) top_ff <= csr_pwdata[ADDR_W-1:0];
            else low_ff <= csr_pwdata[ADDR_W-1:0];
         end
         if (head_we) head_ff[hsel] <= head_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         type_ff <= req_type;
         cpu_ff <= req_cpu_id;
         addr_ff <= req_page_addr_in;
      end
      if (state_ff == S_DECODE) begin
         c_ff <= '0;
         taken_ff <= '0;
         i_ff <= '0;
         pidx_ff <= head_rd[IDX_W-1:0];
      end
      if (state_ff == S_SCAN && scan_skip && !scan_done) c_ff <= c_ff + CW'(1);
      if (buf_we) begin
         buf_mem[taken_ff[BUF_AW-1:0]] <= head_rd[IDX_W-1:0];
         taken_ff <= taken_ff + CNT_W'(1);
      end
      buf_rd_ff <= buf_mem[i_ff[BUF_AW-1:0]];
      if (state_ff == S_PUSH_WR) begin
         prev_ff <= buf_rd_ff;
         i_ff <= i_ff + CNT_W'(1);
      end
      if (rsp_set) begin
         rsp_addr_ff <= rsp_addr_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[3] ? CSR_DATA_W'(top_ff) : CSR_DATA_W'(low_ff);
   assign busy = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_page_addr_out = rsp_addr_ff;
   assign rsp_status = rsp_status_ff;

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy)) else $error("result strobe without a busy item");
   a_fail_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_OK |-> rsp_page_addr_out == '0)
      else $error("failed item carries an address");
   a_taken_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> taken_ff <= CNT_W'(STEAL_MAX))
      else $error("steal count beyond limit");
   a_push_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PUSH_RD |-> taken_ff != '0) else $error("relink with nothing stolen");
endmodule
